>>> rtl/sei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sei_pkg: shared types and constants of the stepper enable interlock
// Request kinds, stop modes, register indexes and the structs passed between
// the pipeline stages.
// -----------------------------------------------------------------------------
package sei_pkg;

   localparam int unsigned KIND_W      = 3;
   localparam int unsigned CODE_W      = 32;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned TICKS_W     = 8;
   localparam int unsigned STARTUP_W   = 11;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   // Only this code releases an emergency stop
   localparam logic [CODE_W-1:0] GOOD_CODE = 32'd3;

   // Reset value of the stop delay register
   localparam logic [TICKS_W-1:0] ESTOP_DELAY_RESET = 8'd50;

   // Request kinds; codes 6 and 7 are unused
   localparam logic [KIND_W-1:0] KIND_POLL    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ESTOP   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ENABLE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FAULT   = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALWAYS_ENABLED    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESTOP_DELAY_TICKS = 1'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF     = 2'd0,
      MODE_ACTIVE  = 2'd1,
      MODE_INVALID = 2'd2
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              tick_seen;
      logic [CODE_W-1:0] auth_code;
      logic              abort_pin;
   } req_type;

   typedef struct packed {
      logic              disable_pin;
      logic              clear_ok;
      logic [MODE_W-1:0] estop_mode;
   } rsp_type;

   typedef struct packed {
      logic               always_enabled;
      logic [TICKS_W-1:0] estop_delay_ticks;
   } cfg_type;

endpackage : sei_pkg
`default_nettype wire

>>> rtl/sei_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sei channels: request, response and register-write interfaces
// Each channel carries valid, ready and its payload; a transfer happens on a
// rising edge with valid and ready both high.
// -----------------------------------------------------------------------------
interface sei_req_if;
   logic                       valid;
   logic                       ready;
   logic [sei_pkg::KIND_W-1:0] kind;
   logic                       tick_seen;
   logic [sei_pkg::CODE_W-1:0] auth_code;
   logic                       abort_pin;

   modport source (output valid, kind, tick_seen, auth_code, abort_pin, input ready);
   modport sink   (input valid, kind, tick_seen, auth_code, abort_pin, output ready);
endinterface : sei_req_if

interface sei_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       disable_pin;
   logic                       clear_ok;
   logic [sei_pkg::MODE_W-1:0] estop_mode;

   modport source (output valid, disable_pin, clear_ok, estop_mode, input ready);
   modport sink   (input valid, disable_pin, clear_ok, estop_mode, output ready);
endinterface : sei_rsp_if

interface sei_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sei_pkg::CSR_INDEX_W-1:0] index;
   logic [sei_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : sei_csr_if
`default_nettype wire

>>> rtl/sei_req_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sei_req_stage: request input register
// Captures one request and holds it until the update stage takes it.
// -----------------------------------------------------------------------------
module sei_req_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sei_pkg::req_type req_item,
   input  wire logic             drain,
   output logic                  item_valid,
   output sei_pkg::req_type      item
);
   import sei_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // Accept when empty or when the held request moves on this cycle
   assign req_ready = !valid_ff || drain;
   assign valid_in  = req_valid || (valid_ff && !drain);

   // Hold valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule : sei_req_stage
`default_nettype wire

>>> rtl/sei_state_update.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sei_state_update: interlock state and its update logic
// Holds stop mode, countdowns and pin state; computes the response of the
// request in the input register and commits the new state when it moves on.
// -----------------------------------------------------------------------------
module sei_state_update #(
   parameter int unsigned STARTUP_DELAY = 1000
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             commit,
   input  wire sei_pkg::req_type item,
   input  wire sei_pkg::cfg_type cfg,
   output sei_pkg::rsp_type      result
);
   import sei_pkg::*;

   localparam logic [STARTUP_W-1:0] STARTUP_RESET = STARTUP_W'(STARTUP_DELAY);

   mode_type               mode_ff,       mode_in;
   logic [TICKS_W-1:0]     stop_cnt_ff,   stop_cnt_in;
   logic [STARTUP_W-1:0]   start_cnt_ff,  start_cnt_in;
   logic                   done_ff,       done_in;
   logic                   pending_ff,    pending_in;
   logic                   pin_ff,        pin_in;
   logic                   clear_ok;

   // Next state for the current request
   always_comb begin
      logic force_off;
      force_off    = 1'b0;
      mode_in      = mode_ff;
      stop_cnt_in  = stop_cnt_ff;
      start_cnt_in = start_cnt_ff;
      done_in      = done_ff;
      pending_in   = pending_ff;
      pin_in       = pin_ff;
      clear_ok     = 1'b0;
      case (item.kind)
         KIND_POLL: begin
            // Startup shot uses the done flag from before this poll
            if (done_ff && pending_ff) begin
               pending_in = 1'b0;
               if (cfg.always_enabled) begin
                  if (mode_ff == MODE_OFF) begin
                     pin_in = 1'b0;
                  end
               end else begin
                  pin_in = 1'b1;
               end
            end
            if (item.tick_seen) begin
               if (mode_ff == MODE_ACTIVE) begin
                  if (stop_cnt_ff != '0) begin
                     stop_cnt_in = stop_cnt_ff - TICKS_W'(1);
                  end else begin
                     force_off = 1'b1;
                  end
               end
               if (!done_ff) begin
                  if (start_cnt_ff != '0) begin
                     start_cnt_in = start_cnt_ff - STARTUP_W'(1);
                  end else begin
                     done_in = 1'b1;
                  end
               end
            end
            if (mode_ff == MODE_INVALID || force_off) begin
               pin_in = 1'b1;
            end
         end
         KIND_ESTOP: begin
            mode_in     = MODE_ACTIVE;
            stop_cnt_in = cfg.estop_delay_ticks;
         end
         KIND_CLEAR: begin
            if (item.auth_code == GOOD_CODE) begin
               if (!item.abort_pin) begin
                  mode_in  = MODE_OFF;
                  clear_ok = 1'b1;
                  if (cfg.always_enabled) begin
                     pin_in = 1'b0;
                  end
               end
            end else begin
               mode_in = MODE_INVALID;
            end
         end
         KIND_ENABLE: begin
            if (mode_ff == MODE_OFF) begin
               pin_in = 1'b0;
            end
         end
         KIND_DISABLE, KIND_FAULT: begin
            pin_in = 1'b1;
         end
         default: begin
            // unused kinds leave state alone
         end
      endcase
   end

   // Commit state when the request moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         stop_cnt_ff  <= '0;
         start_cnt_ff <= STARTUP_RESET;
         done_ff      <= 1'b0;
         pending_ff   <= 1'b1;
         pin_ff       <= 1'b1;
      end else if (commit) begin
         mode_ff      <= mode_in;
         stop_cnt_ff  <= stop_cnt_in;
         start_cnt_ff <= start_cnt_in;
         done_ff      <= done_in;
         pending_ff   <= pending_in;
         pin_ff       <= pin_in;
      end
   end

   assign result.disable_pin = pin_in;
   assign result.clear_ok    = clear_ok;
   assign result.estop_mode  = mode_in;

endmodule : sei_state_update
`default_nettype wire

>>> rtl/sei_rsp_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sei_rsp_stage: response output register
// Holds a finished response until the consumer takes it.
// -----------------------------------------------------------------------------
module sei_rsp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire sei_pkg::rsp_type result,
   output logic                  free,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sei_pkg::rsp_type      rsp_item
);
   import sei_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type item_ff;

   // Free when empty or being taken this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   // Hold valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load response
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule : sei_rsp_stage
`default_nettype wire

>>> rtl/stepper_enable_safety_interlock_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// stepper_enable_safety_interlock_unit: stepper disable-pin safety interlock
// Drives the motor disable pin from polls, emergency stops, clears and
// enable/disable/fault requests, returning one response per request.
// -----------------------------------------------------------------------------
// Each request yields exactly one response carrying the disable pin, whether a
// clear released the stop, and the stop mode after the request. A request waits
// in the input register until the output register is free; the update logic
// settles the new state from it, and the response lands in the output register
// when the request moves on. One request per cycle is sustained while the
// consumer keeps up. Register writes are always ready and must only be issued
// while no request is in flight. The pin comes out of reset disabled; the startup
// delay takes STARTUP_DELAY + 1 ticked polls before the startup shot fires.
module stepper_enable_safety_interlock_unit #(
   parameter int unsigned STARTUP_DELAY = 1000
) (
   input  wire logic clock,
   input  wire logic reset,
   sei_req_if.sink   req_chan,
   sei_rsp_if.source rsp_chan,
   sei_csr_if.sink   csr_chan
);
   import sei_pkg::*;

   cfg_type cfg_ff;
   req_type req_item;
   req_type item;
   rsp_type result;
   rsp_type rsp_item;
   logic    item_valid;
   logic    drain;
   logic    commit;

   // Register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.always_enabled    <= 1'b0;
         cfg_ff.estop_delay_ticks <= ESTOP_DELAY_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ALWAYS_ENABLED:    cfg_ff.always_enabled    <= csr_chan.data[0];
            CSR_ESTOP_DELAY_TICKS: cfg_ff.estop_delay_ticks <= csr_chan.data[TICKS_W-1:0];
         endcase
      end
   end

   // Request payload
   assign req_item.kind      = req_chan.kind;
   assign req_item.tick_seen = req_chan.tick_seen;
   assign req_item.auth_code = req_chan.auth_code;
   assign req_item.abort_pin = req_chan.abort_pin;

   assign commit = item_valid && drain;

   sei_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_item),
      .drain      (drain),
      .item_valid (item_valid),
      .item       (item)
   );

   sei_state_update #(
      .STARTUP_DELAY (STARTUP_DELAY)
   ) u_state_update (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   sei_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (commit),
      .result    (result),
      .free      (drain),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   // Response payload
   assign rsp_chan.disable_pin = rsp_item.disable_pin;
   assign rsp_chan.clear_ok    = rsp_item.clear_ok;
   assign rsp_chan.estop_mode  = rsp_item.estop_mode;

   // A successful clear always reports the stop as off
   a_clear_ok_mode_off : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.clear_ok |-> rsp_chan.estop_mode == MODE_OFF)
      else $error("clear_ok reported with stop mode not off");

   // A committed request shows up as a response next cycle
   a_commit_rsp : assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_chan.valid)
      else $error("committed request produced no response");

   // Disable and fault requests always leave the pin disabled
   a_disable_wins : assert property (@(posedge clock) disable iff (reset)
      commit && (item.kind == KIND_DISABLE || item.kind == KIND_FAULT)
      |=> rsp_chan.disable_pin)
      else $error("disable or fault request left motors enabled");

endmodule : stepper_enable_safety_interlock_unit
`default_nettype wire

>>> tb/stepper_enable_safety_interlock_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stepper_enable_safety_interlock_unit_tb: self-checking interlock regression
// Pushes polls, stops, clears and enable/disable/fault requests through the
// interlock under several register settings and idle patterns. It tracks the
// interlock state in step with each accepted request and compares every
// response against it, field by field.
// -----------------------------------------------------------------------------
module stepper_enable_safety_interlock_unit_tb;
   import sei_pkg::*;

   // Short startup so the startup shot lands inside the directed part
   localparam int unsigned STARTUP_TICKS = 6;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASE_ITEMS   = 290;
   localparam int unsigned RESET_CYCLES  = 7;

   // Unused request kinds
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;

   sei_req_if req_bus ();
   sei_rsp_if rsp_bus ();
   sei_csr_if csr_bus ();

   stepper_enable_safety_interlock_unit #(
      .STARTUP_DELAY(STARTUP_TICKS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // Registers and state of the interlock as tracked here
   logic                 cfg_always_enabled;
   logic [TICKS_W-1:0]   cfg_stop_delay;
   mode_type             stop_mode_q;
   logic [TICKS_W-1:0]   stop_ticks_left;
   logic [STARTUP_W-1:0] startup_ticks_left;
   logic                 startup_done;
   logic                 startup_shot_armed;
   logic                 pin_disabled;

   req_type     pending_requests[$];
   rsp_type     predicted_reports[$];
   req_type     in_flight;
   rsp_type     expected_report;
   rsp_type     seen_report;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatches     = 0;
   int unsigned cycles         = 0;

   // Clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the tracked interlock by one request and return its response
   function automatic rsp_type advance_interlock(input req_type r);
      rsp_type report;
      logic    force_off;
      logic    released;
      force_off = 1'b0;
      released  = 1'b0;
      case (r.kind)
         KIND_POLL: begin
            // the one startup shot looks at startup_done as it was before this poll
            if (startup_done && startup_shot_armed) begin
               startup_shot_armed = 1'b0;
               if (!cfg_always_enabled)
                  pin_disabled = 1'b1;
               else if (stop_mode_q == MODE_OFF)
                  pin_disabled = 1'b0;
            end
            if (r.tick_seen) begin
               if (stop_mode_q == MODE_ACTIVE) begin
                  if (stop_ticks_left != '0)
                     stop_ticks_left = stop_ticks_left - 1'b1;
                  else
                     force_off = 1'b1;
               end
               if (!startup_done) begin
                  if (startup_ticks_left != '0)
                     startup_ticks_left = startup_ticks_left - 1'b1;
                  else
                     startup_done = 1'b1;
               end
            end
            if (stop_mode_q != MODE_OFF && stop_mode_q != MODE_ACTIVE)
               pin_disabled = 1'b1;
            if (force_off)
               pin_disabled = 1'b1;
         end
         KIND_ESTOP: begin
            stop_mode_q     = MODE_ACTIVE;
            stop_ticks_left = cfg_stop_delay;
         end
         KIND_CLEAR: begin
            if (r.auth_code != GOOD_CODE) begin
               stop_mode_q = MODE_INVALID;
            end else if (!r.abort_pin) begin
               stop_mode_q = MODE_OFF;
               released    = 1'b1;
               if (cfg_always_enabled)
                  pin_disabled = 1'b0;
            end
         end
         KIND_ENABLE: begin
            if (stop_mode_q == MODE_OFF)
               pin_disabled = 1'b0;
         end
         KIND_DISABLE, KIND_FAULT: begin
            pin_disabled = 1'b1;
         end
         default: begin
         end
      endcase
      report.disable_pin = pin_disabled;
      report.clear_ok    = released;
      report.estop_mode  = stop_mode_q;
      return report;
   endfunction

   function automatic req_type make_request(input logic [KIND_W-1:0] kind, input logic tick,
                                            input logic [CODE_W-1:0] code, input logic abort);
      req_type r;
      r.kind      = kind;
      r.tick_seen = tick;
      r.auth_code = code;
      r.abort_pin = abort;
      return r;
   endfunction

   // Mostly the good code, sometimes its neighbors, the extremes or noise
   function automatic logic [CODE_W-1:0] clear_code();
      case ($urandom_range(0, 9))
         0: return '1;
         1: return '0;
         2: return GOOD_CODE - 32'd1;
         3: return GOOD_CODE + 32'd1;
         4: return $urandom();
         default: return GOOD_CODE;
      endcase
   endfunction

   function automatic req_type random_request();
      int unsigned pick;
      req_type     r;
      r = make_request(KIND_POLL, 1'($urandom_range(0, 1)), $urandom(),
                       1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.kind = KIND_POLL;
      end else if (pick < 51) begin
         r.kind = KIND_ESTOP;
      end else if (pick < 63) begin
         r.kind      = KIND_CLEAR;
         r.auth_code = clear_code();
      end else if (pick < 77) begin
         r.kind = KIND_ENABLE;
      end else if (pick < 85) begin
         r.kind = KIND_DISABLE;
      end else if (pick < 92) begin
         r.kind = KIND_FAULT;
      end else begin
         r.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
      end
      return r;
   endfunction

   // Queue random traffic, much of it stop episodes that tick toward the
   // forced disable and end in a clear attempt
   task automatic queue_traffic(input int unsigned count);
      int unsigned made;
      int unsigned polls;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 99) < 35) begin
            pending_requests.push_back(make_request(KIND_ESTOP, 1'($urandom_range(0, 1)),
                                                    $urandom(), 1'($urandom_range(0, 1))));
            polls = $urandom_range(0, (cfg_stop_delay > 36) ? 40 : cfg_stop_delay + 4);
            repeat (polls) begin
               if ($urandom_range(0, 99) < 12)
                  pending_requests.push_back(random_request());
               else
                  pending_requests.push_back(make_request(KIND_POLL,
                     1'($urandom_range(0, 3) != 0), $urandom(), 1'($urandom_range(0, 1))));
            end
            pending_requests.push_back(make_request(KIND_CLEAR, 1'($urandom_range(0, 1)),
                                                    clear_code(), 1'($urandom_range(0, 3) == 0)));
            made += polls + 2;
         end else begin
            pending_requests.push_back(random_request());
            made++;
         end
      end
   endtask

   // Write one register and track it once the write is taken
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      if (idx == CSR_ALWAYS_ENABLED)
         cfg_always_enabled = value[0];
      else if (idx == CSR_ESTOP_DELAY_TICKS)
         cfg_stop_delay = value;
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until every request is sent and answered, then let the pipe settle
   task automatic wait_until_idle();
      while (pending_requests.size() != 0 || req_bus.valid || predicted_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic always_en, input logic [TICKS_W-1:0] delay,
                            input int unsigned send_pct, input int unsigned recv_pct);
      write_register(CSR_ALWAYS_ENABLED, {7'($urandom_range(0, 127)), always_en});
      write_register(CSR_ESTOP_DELAY_TICKS, delay);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queue_traffic(PHASE_ITEMS);
      wait_until_idle();
   endtask

   // Request driver: track the request taken at this edge, then offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predicted_reports.push_back(advance_interlock(in_flight));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               in_flight = pending_requests.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.kind      <= in_flight.kind;
               req_bus.tick_seen <= in_flight.tick_seen;
               req_bus.auth_code <= in_flight.auth_code;
               req_bus.abort_pin <= in_flight.abort_pin;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each response against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_report.disable_pin = rsp_bus.disable_pin;
            seen_report.clear_ok    = rsp_bus.clear_ok;
            seen_report.estop_mode  = rsp_bus.estop_mode;
            if (predicted_reports.size() == 0) begin
               $display("%0t: response with none expected: pin %0b ok %0b mode %0d", $time,
                        seen_report.disable_pin, seen_report.clear_ok, seen_report.estop_mode);
               mismatches++;
            end else begin
               expected_report = predicted_reports.pop_front();
               if (seen_report.disable_pin !== expected_report.disable_pin ||
                   seen_report.clear_ok !== expected_report.clear_ok ||
                   seen_report.estop_mode !== expected_report.estop_mode) begin
                  $display("%0t: response mismatch: expected pin %0b ok %0b mode %0d, got pin %0b ok %0b mode %0d",
                           $time, expected_report.disable_pin, expected_report.clear_ok,
                           expected_report.estop_mode, seen_report.disable_pin,
                           seen_report.clear_ok, seen_report.estop_mode);
                  mismatches++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("stepper_enable_safety_interlock_unit regression: fail");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.kind      = KIND_POLL;
      req_bus.tick_seen = 1'b0;
      req_bus.auth_code = '0;
      req_bus.abort_pin = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_ALWAYS_ENABLED;
      csr_bus.data      = '0;

      cfg_always_enabled = 1'b0;
      cfg_stop_delay     = ESTOP_DELAY_RESET;
      stop_mode_q        = MODE_OFF;
      stop_ticks_left    = '0;
      startup_ticks_left = STARTUP_W'(STARTUP_TICKS);
      startup_done       = 1'b0;
      startup_shot_armed = 1'b1;
      pin_disabled       = 1'b1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Startup under a pending stop; delay register left at its reset value
      write_register(CSR_ALWAYS_ENABLED, 8'd1);
      pending_requests.push_back(make_request(KIND_POLL, 1'b0, '1, 1'b1));
      pending_requests.push_back(make_request(KIND_ESTOP, 1'b0, '0, 1'b0));
      repeat (STARTUP_TICKS + 1)
         pending_requests.push_back(make_request(KIND_POLL, 1'b1, $urandom(), 1'b0));
      // shot meets an active stop: pin must stay disabled
      pending_requests.push_back(make_request(KIND_POLL, 1'b0, '0, 1'b0));
      // good code with abort high is refused, then accepted with abort low
      pending_requests.push_back(make_request(KIND_CLEAR, 1'b0, GOOD_CODE, 1'b1));
      pending_requests.push_back(make_request(KIND_CLEAR, 1'b1, GOOD_CODE, 1'b0));
      // wrong code: invalid mode, pin untouched until the next poll
      pending_requests.push_back(make_request(KIND_CLEAR, 1'b0, '0, 1'b0));
      pending_requests.push_back(make_request(KIND_POLL, 1'b0, '0, 1'b0));
      pending_requests.push_back(make_request(KIND_ENABLE, 1'b1, '1, 1'b1));
      pending_requests.push_back(make_request(KIND_CLEAR, 1'b0, GOOD_CODE, 1'b0));
      pending_requests.push_back(make_request(KIND_FAULT, 1'b1, '1, 1'b1));
      wait_until_idle();

      // Zero stop delay: the first ticked poll after a stop forces a disable
      write_register(CSR_ALWAYS_ENABLED, 8'd0);
      write_register(CSR_ESTOP_DELAY_TICKS, 8'd0);
      pending_requests.push_back(make_request(KIND_ENABLE, 1'b0, '0, 1'b0));
      pending_requests.push_back(make_request(KIND_ESTOP, 1'b1, '1, 1'b1));
      pending_requests.push_back(make_request(KIND_POLL, 1'b0, '1, 1'b1));
      pending_requests.push_back(make_request(KIND_POLL, 1'b1, '0, 1'b0));
      // release without auto enable leaves the pin disabled
      pending_requests.push_back(make_request(KIND_CLEAR, 1'b1, GOOD_CODE, 1'b0));
      pending_requests.push_back(make_request(KIND_ENABLE, 1'b1, '1, 1'b1));
      pending_requests.push_back(make_request(KIND_DISABLE, 1'b1, '1, 1'b1));
      pending_requests.push_back(make_request(KIND_SPARE_LO, 1'b1, '1, 1'b1));
      pending_requests.push_back(make_request(KIND_SPARE_HI, 1'b0, '0, 1'b0));
      wait_until_idle();

      // Random phases across settings and idle patterns
      run_phase(1'b1, 8'd0, 0, 0);
      run_phase(1'b0, 8'd255, 48, 0);
      run_phase(1'b1, 8'($urandom_range(1, 8)), 0, 48);
      run_phase(1'b0, 8'($urandom_range(0, 20)), 37, 37);
      run_phase(1'b1, 8'd3, 0, 0);

      if (mismatches == 0 && predicted_reports.size() == 0)
         $display("stepper_enable_safety_interlock_unit regression: pass");
      else
         $display("stepper_enable_safety_interlock_unit regression: fail");
      $finish;
   end

endmodule : stepper_enable_safety_interlock_unit_tb
